// File: hdl/vtdi_pkg.sv
// Shared constants for the vertex triple deduplicating indexer.
// Depends on nothing; imported by the top level.
`default_nettype none

package vtdi_pkg;

	// Default table size and stored index width.
	localparam int unsigned TABLE_DEPTH_DEF = 1024;
	localparam int unsigned INDEX_BITS_DEF  = 16;

	// Fixed widths of the corner and result fields.
	localparam int unsigned FIELD_W = 16;
	localparam int unsigned ELEM_W  = 10;

endpackage

`default_nettype wire

// File: hdl/vertex_triple_dedup_indexer_unit.sv
// Top level of the vertex triple deduplicating indexer.
// Depends on vtdi_pkg and on the generic table RAM vtdi_ram.
//
// Use: a face corner (vertex, texture and normal index) is offered with start
// and is taken at a clock edge where start is high and busy is low. Setting
// new_mesh with a corner empties the table before that corner is looked up.
// Each corner yields exactly one result beat: done is high for one cycle with
// elem_num, is_new and overflow valid; the receiver cannot stall it.
// The distinct triples live in one synchronous RAM in order of first
// appearance. The lookup walks that RAM from entry zero, one read per cycle,
// and compares each registered read with the key; it stops at the first
// match, or, for a triple not yet stored, once every stored entry (counted
// after any new_mesh clear has been applied) has been compared. A new
// triple is written at the next free entry in its result cycle; a full
// table gives overflow and stores nothing. busy falls in the same cycle that
// done rises, so the next corner can be taken at the edge that ends the
// result cycle; no new corner is taken while one is being looked up. The
// table RAM's single read port sets the pace of the walk. Reset empties the
// table at once (only the fill count is cleared) and the block is ready in
// the first cycle after reset is released.
`default_nettype none

module vertex_triple_dedup_indexer_unit
	import vtdi_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int unsigned INDEX_BITS  = INDEX_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               new_mesh,
	input  wire logic [FIELD_W-1:0] vtx_idx,
	input  wire logic [FIELD_W-1:0] tex_idx,
	input  wire logic [FIELD_W-1:0] nrm_idx,
	output logic                    done,
	output logic [ELEM_W-1:0]       elem_num,
	output logic                    is_new,
	output logic                    overflow
);

	localparam int unsigned KEY_W = 3 * INDEX_BITS;
	localparam int unsigned AW    = $clog2(TABLE_DEPTH);
	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t           state_q;
	logic [KEY_W-1:0] key_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] scan_q;
	logic             pend_s1;
	logic [AW-1:0]    addr_s1;

	logic [KEY_W-1:0] rd_data;
	logic             hit;
	logic             more;
	logic             room;
	logic             rd_en;
	logic             wr_en;

	// A pending read whose data equals the key is the match; entries are
	// unique, so the first one seen is the only one.
	assign hit   = (state_q == ST_SCAN) && pend_s1 && (rd_data == key_q);
	assign more  = scan_q < count_q;
	assign room  = count_q < CNT_W'(TABLE_DEPTH);
	assign rd_en = (state_q == ST_SCAN) && !hit && more;
	assign wr_en = (state_q == ST_SCAN) && !hit && !more && room;

	vtdi_ram #(
		.WIDTH (KEY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[AW-1:0]),
		.wdata (key_q),
		.re    (rd_en),
		.raddr (scan_q[AW-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			busy     <= 1'b0;
			done     <= 1'b0;
			count_q  <= '0;
			scan_q   <= '0;
			pend_s1  <= 1'b0;
			addr_s1  <= '0;
			key_q    <= '0;
			elem_num <= '0;
			is_new   <= 1'b0;
			overflow <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						key_q   <= {INDEX_BITS'(nrm_idx), INDEX_BITS'(tex_idx),
							INDEX_BITS'(vtx_idx)};
						scan_q  <= '0;
						pend_s1 <= 1'b0;
						busy    <= 1'b1;
						state_q <= ST_SCAN;
						if (new_mesh) begin
							count_q <= '0;
						end
					end
				end
				ST_SCAN: begin
					if (hit) begin
						done     <= 1'b1;
						elem_num <= ELEM_W'(addr_s1);
						is_new   <= 1'b0;
						overflow <= 1'b0;
						pend_s1  <= 1'b0;
						busy     <= 1'b0;
						state_q  <= ST_IDLE;
					end else if (more) begin
						pend_s1 <= 1'b1;
						addr_s1 <= scan_q[AW-1:0];
						scan_q  <= scan_q + 1'b1;
					end else begin
						// Every stored entry has been compared without a match.
						done    <= 1'b1;
						pend_s1 <= 1'b0;
						busy    <= 1'b0;
						state_q <= ST_IDLE;
						if (room) begin
							elem_num <= ELEM_W'(count_q);
							is_new   <= 1'b1;
							overflow <= 1'b0;
							count_q  <= count_q + 1'b1;
						end else begin
							elem_num <= '0;
							is_new   <= 1'b0;
							overflow <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hdl/vtdi_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; used by the vertex triple deduplicating indexer for its table.
`default_nettype none

module vtdi_ram #(
	parameter int unsigned WIDTH = 48,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire
